// ===== rtl/pnu_pkg.sv =====
// Shared types, constants and saturating helpers for the proof-number node update.
// No dependencies; every other file of the block imports this package.
package pnu_pkg;

    // Proof and disproof numbers are 63 bits; infinity is 2^62
    localparam int VAL_W = 63;
    localparam int IDX_W = 8;
    localparam logic [VAL_W-1:0] INF = {1'b1, {(VAL_W-1){1'b0}}};
    localparam int MAX_CHILDREN_DEF = 256;

    // Stream widths
    localparam int S_TDATA_W = 256;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 264;
    localparam int M_TUSER_W = 1;

    // One child item as taken from the input channel
    typedef struct packed {
        logic [VAL_W-1:0] child_pn;
        logic [VAL_W-1:0] child_dn;
        logic             child_repeats;
        logic             last_child;
        logic             empty_node;
        logic             or_node;
        logic [VAL_W-1:0] pn_threshold;
        logic [VAL_W-1:0] dn_threshold;
    } item_t;

    // Aggregated node, handed from the accumulator to the finishing stages
    typedef struct packed {
        logic             empty;
        logic             kind;
        logic [VAL_W-1:0] pn;
        logic [VAL_W-1:0] dn;
        logic [VAL_W-1:0] best_value;
        logic [VAL_W-1:0] second_value;
        logic [IDX_W-1:0] best_index;
        logic [VAL_W-1:0] best_other;
        logic [VAL_W-1:0] other_sum;
        logic [VAL_W-1:0] held_pn_thr;
        logic [VAL_W-1:0] held_dn_thr;
    } summary_t;

    // One result item
    typedef struct packed {
        logic [VAL_W-1:0] node_pn;
        logic [VAL_W-1:0] node_dn;
        logic             best_found;
        logic [IDX_W-1:0] best_index;
        logic [VAL_W-1:0] next_pn_threshold;
        logic [VAL_W-1:0] next_dn_threshold;
    } result_t;

    // Add with saturation at infinity
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y);
        logic [VAL_W-1:0] s;
        s = x + y;
        if (x >= INF || y >= INF) begin
            return INF;
        end
        return (s > INF) ? INF : s;
    endfunction

    function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y);
        return (x < y) ? x : y;
    endfunction

endpackage

// ===== rtl/pnu_accum.sv =====
// Per-child accumulator: running min/sum, best and second-best selection.
// Depends on pnu_pkg; feeds a node summary register to pnu_finish.
module pnu_accum
    import pnu_pkg::*;
#(
    parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  item_t    item,
    output logic     sum_valid,
    input  logic     sum_ready,
    output summary_t summary
);

    localparam int CW = $clog2(MAX_CHILDREN);
    localparam logic [CW-1:0] LAST_POS = CW'(MAX_CHILDREN - 1);

    logic             in_node_reg;
    logic             kind_reg;
    logic [CW-1:0]    count_reg;
    logic [VAL_W-1:0] pn_reg, dn_reg;
    logic [VAL_W-1:0] best_reg, second_reg;
    logic [CW-1:0]    pos_reg;
    logic [VAL_W-1:0] bo_reg, os_reg;
    logic [VAL_W-1:0] hpn_reg, hdn_reg;
    logic             sum_valid_reg;
    summary_t         summary_reg;

    logic             start, kind, produces, sum_free, fire;
    logic [CW-1:0]    cur_count, cur_pos, count_next, pos_next;
    logic [VAL_W-1:0] cur_pn, cur_dn, cur_best, cur_second, cur_bo, cur_os;
    logic [VAL_W-1:0] hpn, hdn;
    logic [VAL_W-1:0] pn_next, dn_next, best_next, second_next, bo_next, os_next;
    logic [VAL_W-1:0] value, other;

    // Start values for the first child, otherwise the held state
    always_comb begin
        start      = !in_node_reg;
        kind       = start ? item.or_node : kind_reg;
        cur_pn     = start ? (item.or_node ? INF : '0) : pn_reg;
        cur_dn     = start ? (item.or_node ? '0 : INF) : dn_reg;
        cur_best   = start ? INF : best_reg;
        cur_second = start ? INF : second_reg;
        cur_bo     = start ? '0 : bo_reg;
        cur_os     = start ? '0 : os_reg;
        cur_count  = start ? '0 : count_reg;
        hpn        = start ? item.pn_threshold : hpn_reg;
        hdn        = start ? item.dn_threshold : hdn_reg;
        cur_pos    = start ? '0 : pos_reg;
    end

    // Fold one child into the aggregate
    always_comb begin
        value       = kind ? item.child_pn : item.child_dn;
        other       = kind ? item.child_dn : item.child_pn;
        pn_next     = kind ? min_val(cur_pn, item.child_pn) : sat_add(cur_pn, item.child_pn);
        dn_next     = kind ? sat_add(cur_dn, item.child_dn) : min_val(cur_dn, item.child_dn);
        best_next   = cur_best;
        second_next = cur_second;
        bo_next     = cur_bo;
        os_next     = cur_os;
        pos_next    = cur_pos;
        if (!item.child_repeats) begin
            os_next = sat_add(cur_os, other);
            if (value < cur_best) begin
                second_next = cur_best;
                best_next   = value;
                pos_next    = cur_count;
                bo_next     = other;
            end else if (value < cur_second) begin
                second_next = value;
            end
        end
        count_next = (cur_count < LAST_POS) ? cur_count + 1'b1 : cur_count;
    end

    // Handshake: only a finishing item needs room downstream
    assign produces  = item.last_child || item.empty_node;
    assign sum_free  = !sum_valid_reg || sum_ready;
    assign in_ready  = !produces || sum_free;
    assign fire      = in_valid && in_ready;
    assign sum_valid = sum_valid_reg;
    assign summary   = summary_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_node_reg   <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                in_node_reg <= !produces;
            end
            if (fire && produces) begin
                sum_valid_reg <= 1'b1;
            end else if (sum_ready) begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the aggregate, or hand it over on the last child or an empty-node item
    always_ff @(posedge aclk) begin
        if (fire && !produces) begin
            kind_reg   <= kind;
            count_reg  <= count_next;
            pn_reg     <= pn_next;
            dn_reg     <= dn_next;
            best_reg   <= best_next;
            second_reg <= second_next;
            pos_reg    <= pos_next;
            bo_reg     <= bo_next;
            os_reg     <= os_next;
            hpn_reg    <= hpn;
            hdn_reg    <= hdn;
        end
        if (fire && produces) begin
            summary_reg.empty        <= item.empty_node;
            summary_reg.kind         <= kind;
            summary_reg.pn           <= pn_next;
            summary_reg.dn           <= dn_next;
            summary_reg.best_value   <= best_next;
            summary_reg.second_value <= second_next;
            summary_reg.best_index   <= IDX_W'(pos_next);
            summary_reg.best_other   <= bo_next;
            summary_reg.other_sum    <= os_next;
            summary_reg.held_pn_thr  <= hpn;
            summary_reg.held_dn_thr  <= hdn;
        end
    end

`ifndef SYNTH
    a_node_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && produces) |=> !in_node_reg)
        else $error("node still open after its final transfer");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_node_reg |-> count_reg <= LAST_POS)
        else $error("child position beyond its limit");

    a_summary_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_valid_reg && !summary_reg.empty) |->
            (summary_reg.pn <= INF && summary_reg.dn <= INF &&
             summary_reg.second_value <= INF && summary_reg.other_sum <= INF))
        else $error("aggregate above infinity");
`endif

endmodule

// ===== rtl/pnu_finish.sv =====
// Finishing stages: child thresholds from the node summary, then the result register.
// Depends on pnu_pkg; takes its summary from pnu_accum.
module pnu_finish
    import pnu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     sum_valid,
    output logic     sum_ready,
    input  summary_t summary,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  result
);

    typedef struct packed {
        logic             empty;
        logic             kind;
        logic             found;
        logic [VAL_W-1:0] pn;
        logic [VAL_W-1:0] dn;
        logic [IDX_W-1:0] best_index;
        logic [VAL_W-1:0] rest;
        logic [VAL_W-1:0] thr;
        logic [VAL_W-1:0] held_sel;
        logic [VAL_W-1:0] held_oth;
    } mid_t;

    logic    mid_valid_reg, res_valid_reg;
    mid_t    mid_reg, mid_next;
    result_t res_reg, res_next;
    logic    res_free, mid_free;
    logic [VAL_W-1:0] sel_th, oth_th, diff;

    assign res_free  = !res_valid_reg || res_ready;
    assign mid_free  = !mid_valid_reg || res_free;
    assign sum_ready = mid_free;
    assign res_valid = res_valid_reg;
    assign result    = res_reg;

    // First half: remaining sum of the other children and the second-best bound
    always_comb begin
        mid_next.empty      = summary.empty;
        mid_next.kind       = summary.kind;
        mid_next.found      = summary.best_value < INF;
        mid_next.pn         = summary.pn;
        mid_next.dn         = summary.dn;
        mid_next.best_index = summary.best_index;
        mid_next.rest       = (summary.other_sum >= summary.best_other) ?
                              summary.other_sum - summary.best_other : '0;
        mid_next.thr        = (summary.second_value >= INF) ? INF :
                              summary.second_value + 1'b1;
        mid_next.held_sel   = summary.kind ? summary.held_pn_thr : summary.held_dn_thr;
        mid_next.held_oth   = summary.kind ? summary.held_dn_thr : summary.held_pn_thr;
    end

    // Second half: clamp both thresholds and assemble the result
    always_comb begin
        diff   = mid_reg.held_oth - mid_reg.rest;
        sel_th = min_val(mid_reg.held_sel, mid_reg.thr);
        oth_th = (mid_reg.held_oth >= mid_reg.rest) ? min_val(INF, diff) : '0;
        if (sel_th == '0) begin
            sel_th = VAL_W'(1);
        end
        if (oth_th == '0) begin
            oth_th = VAL_W'(1);
        end
        res_next.node_pn           = mid_reg.pn;
        res_next.node_dn           = mid_reg.dn;
        res_next.best_found        = mid_reg.found;
        res_next.best_index        = mid_reg.best_index;
        res_next.next_pn_threshold = mid_reg.kind ? sel_th : oth_th;
        res_next.next_dn_threshold = mid_reg.kind ? oth_th : sel_th;
        if (mid_reg.empty) begin
            res_next            = '0;
            res_next.node_pn    = INF;
        end else if (!mid_reg.found) begin
            res_next.best_index        = '0;
            res_next.next_pn_threshold = '0;
            res_next.next_dn_threshold = '0;
        end
    end

    // Valid flags of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (mid_free) begin
                mid_valid_reg <= sum_valid;
            end
            if (res_free) begin
                res_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (mid_free && sum_valid) begin
            mid_reg <= mid_next;
        end
        if (res_free && mid_valid_reg) begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTH
    a_found_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.best_found) |->
            (res_reg.next_pn_threshold != '0 && res_reg.next_dn_threshold != '0))
        else $error("selected child given a zero threshold");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !res_reg.best_found) |->
            (res_reg.best_index == '0 && res_reg.next_pn_threshold == '0 &&
             res_reg.next_dn_threshold == '0))
        else $error("no selection but child fields set");

    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> (res_reg.node_pn <= INF && res_reg.node_dn <= INF &&
                           res_reg.next_pn_threshold <= INF &&
                           res_reg.next_dn_threshold <= INF))
        else $error("result above infinity");
`endif

endmodule

// ===== rtl/proof_number_node_update.sv =====
// Top level of the proof-number node update: input register, accumulator, finishing stages.
// Depends on pnu_pkg, pnu_accum and pnu_finish.
//
// Children of one AND/OR node arrive one per transfer, last_child on s_tlast.
// The block takes one child per cycle when not stalled; the limit is the
// accumulator feedback loop (saturating add, minimum and best/second compare
// on 63-bit values), which folds one child per cycle. A node result reaches
// the master side after its last child (or empty-node item) is transferred
// in, passing four registers: input register, accumulator, threshold stage,
// result register. Children beyond MAX_CHILDREN-1 are still folded in but
// share the last position. No clearing pass follows reset.
module proof_number_node_update
    import pnu_pkg::*;
#(
    parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // child_pn [62:0], child_dn [125:63], pn_threshold [188:126],
    // dn_threshold [251:189], zero [255:252]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // child_repeats [0], empty_node [1], or_node [2]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // node_pn [62:0], node_dn [125:63], best_index [133:126],
    // next_pn_threshold [196:134], next_dn_threshold [259:197], zero [263:260]
    output logic [M_TDATA_W-1:0] m_tdata,
    // best_found [0]
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic     in_valid_reg;
    item_t    item_reg, item_next;
    logic     acc_ready;
    logic     sum_valid, sum_ready;
    summary_t summary;
    result_t  result;

    // Unpack the slave-side transfer
    always_comb begin
        item_next.child_pn      = s_tdata[VAL_W-1:0];
        item_next.child_dn      = s_tdata[2*VAL_W-1:VAL_W];
        item_next.pn_threshold  = s_tdata[3*VAL_W-1:2*VAL_W];
        item_next.dn_threshold  = s_tdata[4*VAL_W-1:3*VAL_W];
        item_next.child_repeats = s_tuser[0];
        item_next.empty_node    = s_tuser[1];
        item_next.or_node       = s_tuser[2];
        item_next.last_child    = s_tlast;
    end

    assign s_tready = !in_valid_reg || acc_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    pnu_accum #(
        .MAX_CHILDREN(MAX_CHILDREN)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (acc_ready),
        .item      (item_reg),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .summary   (summary)
    );

    pnu_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .summary   (summary),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .result    (result)
    );

    // Pack the master-side transfer
    assign m_tdata = {4'b0000, result.next_dn_threshold, result.next_pn_threshold,
                      result.best_index, result.node_dn, result.node_pn};
    assign m_tuser = result.best_found;

endmodule
